/* rtl/core/evr_pkg.sv */
package evr_pkg;

    localparam int RING_DEPTH_DEF  = 256;
    localparam int MAX_RUN_DEF     = 32;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Widths wide enough for the largest ring and run the block supports.
    localparam int SLOT_W  = 16;
    localparam int AVAIL_W = 17;
    localparam int RUN_W   = 7;

    localparam logic [1:0] REQ_EMIT     = 2'd0;
    localparam logic [1:0] REQ_SNAPSHOT = 2'd1;
    localparam logic [1:0] REQ_QUERY    = 2'd2;

    typedef logic [63:0]        word_t;
    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [AVAIL_W-1:0] avail_t;
    typedef logic [RUN_W-1:0]   run_t;

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_RUN,
        CMD_STATS
    } cmd_kind_t;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } back_state_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] event_time;
        logic [63:0] now_time;
        logic [63:0] event_payload;
        logic [63:0] cursor_seq;
        logic [5:0]  event_limit;
    } request_t;

    typedef struct packed {
        logic        has_event;
        logic [63:0] event_seq;
        logic [63:0] event_stamp;
        logic [63:0] event_body;
        logic [63:0] oldest_sequence;
        logic [63:0] next_sequence;
        logic [63:0] lost_count;
        logic        last;
    } result_t;

    typedef struct packed {
        word_t oldest_seq;
        word_t issue_seq;
        word_t lost;
    } stats_t;

    typedef struct packed {
        cmd_kind_t kind;
        slot_t     slot;
        run_t      run_len;
        avail_t    avail;
        word_t     stamp;
        word_t     body;
        stats_t    stats;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

/* rtl/core/evr_front.sv */
module evr_front #(
    parameter int RING_DEPTH = evr_pkg::RING_DEPTH_DEF,
    parameter int MAX_RUN    = evr_pkg::MAX_RUN_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  evr_pkg::request_t      request,
    input  evr_pkg::queue_status_t q_status,
    output logic                   busy,
    output logic                   push,
    output evr_pkg::cmd_t          push_cmd
);

    localparam int PTR_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int HELD_W = $clog2(RING_DEPTH + 1);
    localparam int CALC_W = HELD_W + 1;

    logic [63:0]       seq_ctr_reg;
    logic [63:0]       seq_ctr_next;
    logic [63:0]       lost_reg;
    logic [63:0]       lost_next;
    logic [HELD_W-1:0] held_reg;
    logic [HELD_W-1:0] held_next;
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;

    logic              accept;
    logic              is_emit;
    logic              is_snap;
    logic              is_query;
    logic              cursor_future;
    logic [63:0]       after_cursor;
    logic [HELD_W-1:0] avail;
    evr_pkg::run_t     max_ext;
    evr_pkg::run_t     limit;
    evr_pkg::run_t     run_len;
    logic [CALC_W-1:0] ptr_ext;
    logic [CALC_W-1:0] avail_ext;
    logic [CALC_W-1:0] start_slot;
    evr_pkg::stats_t   stats;

    assign busy     = q_status.full;
    assign accept   = start && !busy;
    assign is_emit  = (request.req_type == evr_pkg::REQ_EMIT);
    assign is_snap  = (request.req_type == evr_pkg::REQ_SNAPSHOT);
    assign is_query = (request.req_type == evr_pkg::REQ_QUERY);
    assign push     = accept && (is_emit || is_snap || is_query);

    assign stats.oldest_seq = seq_ctr_reg - 64'(held_reg);
    assign stats.issue_seq  = seq_ctr_reg;
    assign stats.lost       = lost_reg;

    // The events after the cursor reach up to the newest entry, so the run
    // starts avail entries below the next sequence number and takes at most
    // run_len of them from there.
    assign cursor_future = (request.cursor_seq >= seq_ctr_reg);
    assign after_cursor  = seq_ctr_reg - request.cursor_seq - 64'd1;

    always_comb
    begin
        if (cursor_future || (after_cursor >= 64'(held_reg)))
        begin
            avail = held_reg;
        end
        else
        begin
            avail = after_cursor[HELD_W-1:0];
        end
    end

    assign max_ext = evr_pkg::run_t'(request.event_limit);
    assign limit   = (max_ext > evr_pkg::run_t'(MAX_RUN)) ? evr_pkg::run_t'(MAX_RUN)
                                                          : max_ext;
    assign run_len = (evr_pkg::avail_t'(avail) < evr_pkg::avail_t'(limit))
                     ? evr_pkg::run_t'(avail) : limit;

    assign ptr_ext    = CALC_W'(wr_ptr_reg);
    assign avail_ext  = CALC_W'(avail);
    assign start_slot = (ptr_ext >= avail_ext) ? (ptr_ext - avail_ext)
                        : (ptr_ext + CALC_W'(RING_DEPTH) - avail_ext);

    always_comb
    begin
        push_cmd.stats   = stats;
        push_cmd.body    = request.event_payload;
        push_cmd.stamp   = (request.event_time == 64'd0) ? request.now_time
                                                         : request.event_time;
        push_cmd.avail   = evr_pkg::avail_t'(avail);
        push_cmd.run_len = run_len;
        if (is_emit)
        begin
            push_cmd.kind = evr_pkg::CMD_WRITE;
            push_cmd.slot = evr_pkg::slot_t'(wr_ptr_reg);
        end
        else if (is_snap && (run_len != '0))
        begin
            push_cmd.kind = evr_pkg::CMD_RUN;
            push_cmd.slot = evr_pkg::slot_t'(start_slot[PTR_W-1:0]);
        end
        else
        begin
            push_cmd.kind = evr_pkg::CMD_STATS;
            push_cmd.slot = evr_pkg::slot_t'(wr_ptr_reg);
        end
    end

    always_comb
    begin
        seq_ctr_next = seq_ctr_reg;
        lost_next    = lost_reg;
        held_next    = held_reg;
        wr_ptr_next  = wr_ptr_reg;
        if (accept && is_emit)
        begin
            seq_ctr_next = seq_ctr_reg + 64'd1;
            wr_ptr_next  = (wr_ptr_reg == PTR_W'(RING_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + 1'b1;
            if (held_reg == HELD_W'(RING_DEPTH))
            begin
                lost_next = lost_reg + 64'd1;
            end
            else
            begin
                held_next = held_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_ctr_reg <= 64'd1;
            lost_reg    <= '0;
            held_reg    <= '0;
            wr_ptr_reg  <= '0;
        end
        else
        begin
            seq_ctr_reg <= seq_ctr_next;
            lost_reg    <= lost_next;
            held_reg    <= held_next;
            wr_ptr_reg  <= wr_ptr_next;
        end
    end

endmodule

/* rtl/core/evr_queue.sv */
module evr_queue #(
    parameter int DEPTH = evr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  evr_pkg::cmd_t          push_cmd,
    input  logic                   pop,
    output evr_pkg::cmd_t          head_cmd,
    output evr_pkg::queue_status_t status
);

    localparam int QP_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    evr_pkg::cmd_t    entries_reg [DEPTH];
    logic [QP_W-1:0]  head_reg;
    logic [QP_W-1:0]  head_next;
    logic [QP_W-1:0]  tail_reg;
    logic [QP_W-1:0]  tail_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign head_cmd     = entries_reg[head_reg];

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push)
        begin
            tail_next = (tail_reg == QP_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        if (pop)
        begin
            head_next = (head_reg == QP_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[tail_reg] <= push_cmd;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !status.full)
        else $error("request written into a full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("queue popped while empty");

    a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue fill count lost a request");
`endif

endmodule

/* rtl/core/evr_back.sv */
module evr_back #(
    parameter int RING_DEPTH = evr_pkg::RING_DEPTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  evr_pkg::cmd_t          head_cmd,
    input  evr_pkg::queue_status_t q_status,
    output logic                   pop,
    output logic                   result_valid,
    output evr_pkg::result_t       result
);

    localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    evr_pkg::back_state_t state_reg;
    evr_pkg::back_state_t state_next;

    logic [63:0]      ring_time [RING_DEPTH];
    logic [63:0]      ring_payload [RING_DEPTH];

    logic             wr_en;
    logic             load_run;
    logic             stats_out;
    logic             rd_en;

    logic [63:0]      seq_reg;
    logic [PTR_W-1:0] slot_reg;
    evr_pkg::run_t    remain_reg;
    evr_pkg::stats_t  run_stats_reg;

    logic             res_valid_reg;
    logic             res_has_reg;
    logic             res_last_reg;
    logic [63:0]      res_seq_reg;
    evr_pkg::stats_t  res_stats_reg;
    logic [63:0]      rd_time_reg;
    logic [63:0]      rd_body_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            evr_pkg::BK_IDLE:
            begin
                if (!q_status.empty && (head_cmd.kind == evr_pkg::CMD_RUN))
                begin
                    state_next = evr_pkg::BK_RUN;
                end
            end
            evr_pkg::BK_RUN:
            begin
                if (remain_reg == evr_pkg::run_t'(1))
                begin
                    state_next = evr_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = evr_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop       = 1'b0;
        wr_en     = 1'b0;
        load_run  = 1'b0;
        stats_out = 1'b0;
        rd_en     = 1'b0;
        case (state_reg)
            evr_pkg::BK_IDLE:
            begin
                pop       = !q_status.empty;
                wr_en     = pop && (head_cmd.kind == evr_pkg::CMD_WRITE);
                load_run  = pop && (head_cmd.kind == evr_pkg::CMD_RUN);
                stats_out = pop && (head_cmd.kind == evr_pkg::CMD_STATS);
            end
            evr_pkg::BK_RUN:
            begin
                rd_en = 1'b1;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= evr_pkg::BK_IDLE;
            remain_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= rd_en || stats_out;
            if (load_run)
            begin
                remain_reg <= head_cmd.run_len;
            end
            else if (rd_en)
            begin
                remain_reg <= remain_reg - 1'b1;
            end
        end
    end

    // The run starts at the oldest event it returns: avail entries below the
    // next sequence number.
    always_ff @(posedge clk)
    begin
        if (load_run)
        begin
            seq_reg       <= head_cmd.stats.issue_seq - 64'(head_cmd.avail);
            slot_reg      <= head_cmd.slot[PTR_W-1:0];
            run_stats_reg <= head_cmd.stats;
        end
        else if (rd_en)
        begin
            seq_reg  <= seq_reg + 64'd1;
            slot_reg <= (slot_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : slot_reg + 1'b1;
        end
        res_has_reg   <= rd_en;
        res_last_reg  <= stats_out || (remain_reg == evr_pkg::run_t'(1));
        res_seq_reg   <= seq_reg;
        res_stats_reg <= rd_en ? run_stats_reg : head_cmd.stats;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_time[head_cmd.slot[PTR_W-1:0]]    <= head_cmd.stamp;
            ring_payload[head_cmd.slot[PTR_W-1:0]] <= head_cmd.body;
        end
        if (rd_en)
        begin
            rd_time_reg <= ring_time[slot_reg];
            rd_body_reg <= ring_payload[slot_reg];
        end
    end

    assign result_valid           = res_valid_reg;
    assign result.has_event       = res_has_reg;
    assign result.event_seq       = res_has_reg ? res_seq_reg : 64'd0;
    assign result.event_stamp     = res_has_reg ? rd_time_reg : 64'd0;
    assign result.event_body      = res_has_reg ? rd_body_reg : 64'd0;
    assign result.oldest_sequence = res_stats_reg.oldest_seq;
    assign result.next_sequence   = res_stats_reg.issue_seq;
    assign result.lost_count      = res_stats_reg.lost;
    assign result.last            = res_last_reg;

`ifndef NO_ASSERTIONS
    a_run_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == evr_pkg::BK_RUN) |-> (remain_reg != '0))
        else $error("event run active with nothing left to read");

    a_run_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == evr_pkg::BK_RUN) |-> !pop)
        else $error("queue popped in the middle of an event run");

    a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_last_reg) |=> (res_valid_reg && res_has_reg))
        else $error("event run broken before its last result");
`endif

endmodule

/* rtl/core/sequenced_event_ring.sv */
// Channel   Direction  Handshake               Payload
// request   in         start high, busy low    request_t
// result    out        result_valid strobe     result_t
//
// An emit or query request passes the four-entry queue and is popped by the back end
// when it is idle; emits are taken one per cycle while busy is low.
// A snapshot of n events makes the back end load the run, then read one event per cycle
// through the single read port of the ring memory.
// busy is high while the queue is full; results cannot be stalled and show once.
// Reset clears the counters and the queue; the ring memory is not cleared.
module sequenced_event_ring #(
    parameter int RING_DEPTH  = evr_pkg::RING_DEPTH_DEF,
    parameter int MAX_RUN     = evr_pkg::MAX_RUN_DEF,
    parameter int QUEUE_DEPTH = evr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  evr_pkg::request_t request,
    output logic              result_valid,
    output evr_pkg::result_t  result
);

    logic                   push;
    logic                   pop;
    evr_pkg::cmd_t          push_cmd;
    evr_pkg::cmd_t          head_cmd;
    evr_pkg::queue_status_t q_status;

    evr_front #(
        .RING_DEPTH (RING_DEPTH),
        .MAX_RUN    (MAX_RUN)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .request  (request),
        .q_status (q_status),
        .busy     (busy),
        .push     (push),
        .push_cmd (push_cmd)
    );

    evr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (q_status)
    );

    evr_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_cmd     (head_cmd),
        .q_status     (q_status),
        .pop          (pop),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

/* test/sequenced_event_ring_tb.sv */
module sequenced_event_ring_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = evr_pkg::RING_DEPTH_DEF;
    localparam int RUN_CAP = evr_pkg::MAX_RUN_DEF;
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_REQUESTS = 400;
    localparam int EXP_W = 10;
    localparam int EXPECT_SLOTS = 1 << EXP_W;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    evr_pkg::request_t request = '0;
    logic result_valid;
    evr_pkg::result_t result;

    // Shadow copy of the ring and its counters.
    logic [63:0] seq_count;
    int unsigned held_count;
    logic [63:0] lost_total;
    logic [63:0] ring_stamp [DEPTH];
    logic [63:0] ring_body [DEPTH];

    // Expected results in order; the writer and the checker each own one count.
    evr_pkg::result_t awaited_results [EXPECT_SLOTS];
    int unsigned exp_wr_cnt = 0;
    int unsigned exp_rd_cnt = 0;
    int errors = 0;
    int idle_cycles = 0;
    bit gaps_on = 1'b1;

    sequenced_event_ring DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .result_valid(result_valid),
        .result(result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic evr_pkg::request_t make_request(logic [1:0] kind, logic [63:0] etime,
                                                       logic [63:0] now, logic [63:0] payload,
                                                       logic [63:0] cursor, logic [5:0] maxev);
        evr_pkg::request_t r;
        r.req_type = kind;
        r.event_time = etime;
        r.now_time = now;
        r.event_payload = payload;
        r.cursor_seq = cursor;
        r.event_limit = maxev;
        return r;
    endfunction

    // Every result carries the window stats as they stand when the request is taken.
    function automatic evr_pkg::result_t window_result(bit has, logic [63:0] seq,
                                                       logic [63:0] stamp,
                                                       logic [63:0] body, bit is_last);
        evr_pkg::result_t res;
        res.has_event = has;
        res.event_seq = seq;
        res.event_stamp = stamp;
        res.event_body = body;
        res.oldest_sequence = seq_count - 64'(held_count);
        res.next_sequence = seq_count;
        res.lost_count = lost_total;
        res.last = is_last;
        return res;
    endfunction

    function automatic void store_expected(input evr_pkg::result_t res);
        if (exp_wr_cnt - exp_rd_cnt >= EXPECT_SLOTS)
        begin
            $display("%0t ns: expected result buffer full, expected room, actual %0d pending",
                     $time, exp_wr_cnt - exp_rd_cnt);
            errors++;
        end
        else
        begin
            awaited_results[exp_wr_cnt[EXP_W-1:0]] = res;
            exp_wr_cnt++;
        end
    endfunction

    task automatic ring_apply(input evr_pkg::request_t r);
        logic [63:0] oldest;
        logic [63:0] cursor;
        logic [63:0] from_seq;
        logic [63:0] limit;
        logic [63:0] count;
        logic [63:0] seq;
        int unsigned slot;
        case (r.req_type)
            evr_pkg::REQ_EMIT:
            begin
                slot = int'((seq_count - 64'd1) % 64'(DEPTH));
                ring_stamp[slot] = (r.event_time == 64'd0) ? r.now_time : r.event_time;
                ring_body[slot] = r.event_payload;
                seq_count = seq_count + 64'd1;
                if (held_count < DEPTH)
                    held_count++;
                else
                    lost_total = lost_total + 64'd1;
            end
            evr_pkg::REQ_SNAPSHOT:
            begin
                oldest = seq_count - 64'(held_count);
                cursor = r.cursor_seq;
                // A cursor from the future restarts the reader at the oldest entry.
                if (cursor >= seq_count)
                    cursor = oldest - 64'd1;
                from_seq = cursor + 64'd1;
                if (from_seq < oldest)
                    from_seq = oldest;
                limit = (r.event_limit > RUN_CAP) ? 64'(RUN_CAP) : 64'(r.event_limit);
                count = 64'd0;
                if (from_seq < seq_count)
                begin
                    count = seq_count - from_seq;
                    if (count > limit)
                        count = limit;
                end
                if (count == 64'd0)
                    store_expected(window_result(1'b0, '0, '0, '0, 1'b1));
                for (int unsigned k = 0; k < count; k++)
                begin
                    seq = from_seq + 64'(k);
                    slot = int'((seq - 64'd1) % 64'(DEPTH));
                    store_expected(window_result(1'b1, seq, ring_stamp[slot],
                                                 ring_body[slot],
                                                 64'(k + 1) == count));
                end
            end
            evr_pkg::REQ_QUERY:
                store_expected(window_result(1'b0, '0, '0, '0, 1'b1));
            default:
                ;
        endcase
    endtask

    task automatic sender_pause();
        if (gaps_on && $urandom_range(0, 99) < 25)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    // Drives one request and holds it until the block takes it.
    task automatic issue_request(input evr_pkg::request_t r);
        sender_pause();
        start <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        ring_apply(r);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (exp_wr_cnt != exp_rd_cnt)
            @(posedge clk);
    endtask

    task automatic emit_random();
        logic [63:0] etime;
        etime = ($urandom_range(0, 4) == 0) ? 64'd0 : rand64();
        issue_request(make_request(evr_pkg::REQ_EMIT, etime, rand64(), rand64(), rand64(),
                                   6'($urandom_range(0, 63))));
    endtask

    // Most cursors land in or just below the held window, so that runs start
    // at many places and stale cursors get clamped once the ring has wrapped.
    function automatic logic [63:0] pick_cursor();
        case ($urandom_range(0, 9))
            0: return 64'd0;
            1: return rand64();
            2: return seq_count + 64'($urandom_range(0, 3));
            3: return '1;
            default: return seq_count - 64'd1 - 64'($urandom_range(0, held_count + 8));
        endcase
    endfunction

    task automatic snapshot_random();
        logic [5:0] maxev;
        maxev = $urandom_range(0, 1) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(1, 12));
        issue_request(make_request(evr_pkg::REQ_SNAPSHOT, rand64(), rand64(), rand64(),
                                   pick_cursor(), maxev));
    endtask

    task automatic test_empty_ring();
        issue_request(make_request(evr_pkg::REQ_QUERY, '0, '0, '0, '0, '0));
        issue_request(make_request(evr_pkg::REQ_SNAPSHOT, rand64(), rand64(), rand64(),
                                   64'd0, 6'd32));
        issue_request(make_request(evr_pkg::REQ_SNAPSHOT, '0, '0, '0, '1, 6'h3f));
        issue_request(make_request(REQ_UNUSED, rand64(), rand64(), rand64(), rand64(), 6'h3f));
    endtask

    task automatic test_stamping();
        // A zero timestamp takes the current time instead.
        issue_request(make_request(evr_pkg::REQ_EMIT, 64'd0, '1, '1, '1, 6'h3f));
        issue_request(make_request(evr_pkg::REQ_EMIT, '1, 64'd0, 64'd0, 64'd0, 6'd0));
        issue_request(make_request(evr_pkg::REQ_EMIT, 64'd1, rand64(), rand64(), rand64(),
                                   6'd1));
        emit_random();
        issue_request(make_request(evr_pkg::REQ_SNAPSHOT, '0, '0, '0, 64'd0, 6'h3f));
    endtask

    task automatic test_cursor_cases();
        emit_random();
        emit_random();
        issue_request(make_request(evr_pkg::REQ_SNAPSHOT, '0, '0, '0, seq_count - 64'd1,
                                   6'd10));
        issue_request(make_request(evr_pkg::REQ_SNAPSHOT, '0, '0, '0, seq_count, 6'd3));
        issue_request(make_request(evr_pkg::REQ_SNAPSHOT, '0, '0, '0, 64'd3, 6'd32));
        issue_request(make_request(evr_pkg::REQ_SNAPSHOT, '0, '0, '0, 64'd2, 6'd0));
        issue_request(make_request(evr_pkg::REQ_SNAPSHOT, '0, '0, '0, 64'd1, 6'd1));
        issue_request(make_request(evr_pkg::REQ_SNAPSHOT, '0, '0, '0, 64'd0, 6'd33));
        issue_request(make_request(evr_pkg::REQ_QUERY, '1, '1, '1, '1, 6'h3f));
    endtask

    task automatic test_random_traffic();
        int sel;
        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            gaps_on = !(i >= 250 && i < 350);
            if (i == 150)
                wait_drained();
            sel = $urandom_range(0, 99);
            if (sel < 70)
                emit_random();
            else if (sel < 90)
                snapshot_random();
            else if (sel < 97)
                issue_request(make_request(evr_pkg::REQ_QUERY, rand64(), rand64(), rand64(),
                                           rand64(), 6'($urandom_range(0, 63))));
            else
                issue_request(make_request(REQ_UNUSED, rand64(), rand64(), rand64(), rand64(),
                                           6'($urandom_range(0, 63))));
        end
    endtask

    task automatic test_stale_cursor();
        issue_request(make_request(evr_pkg::REQ_SNAPSHOT, '0, '0, '0, 64'd0, 6'h3f));
        issue_request(make_request(evr_pkg::REQ_SNAPSHOT, '0, '0, '0,
                                   seq_count - 64'(held_count) - 64'd1, 6'd2));
        issue_request(make_request(evr_pkg::REQ_QUERY, '0, '0, '0, '0, '0));
    endtask

    task automatic check_field(input string name, input logic [63:0] want_v,
                               input logic [63:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        evr_pkg::result_t want;
        if (rst_n && result_valid !== 1'b0)
        begin
            if (exp_rd_cnt == exp_wr_cnt)
            begin
                $display("%0t ns: result with nothing expected, expected none, actual %h",
                         $time, result);
                errors++;
            end
            else
            begin
                want = awaited_results[exp_rd_cnt[EXP_W-1:0]];
                exp_rd_cnt++;
                check_field("has_event", 64'(want.has_event), 64'(result.has_event));
                check_field("event_seq", want.event_seq, result.event_seq);
                check_field("event_stamp", want.event_stamp, result.event_stamp);
                check_field("event_body", want.event_body, result.event_body);
                check_field("oldest_sequence", want.oldest_sequence, result.oldest_sequence);
                check_field("next_sequence", want.next_sequence, result.next_sequence);
                check_field("lost_count", want.lost_count, result.lost_count);
                check_field("last", 64'(want.last), 64'(result.last));
            end
        end
    end

    // Ends the run if neither a request nor a result moves for too long.
    always @(posedge clk)
    begin
        if ((rst_n && start && busy === 1'b0) || result_valid === 1'b1)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        seq_count = 64'd1;
        held_count = 0;
        lost_total = 64'd0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_ring();
        test_stamping();
        test_cursor_cases();
        test_random_traffic();
        test_stale_cursor();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && exp_wr_cnt == exp_rd_cnt)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* files.f */
rtl/core/evr_pkg.sv
rtl/core/evr_front.sv
rtl/core/evr_queue.sv
rtl/core/evr_back.sv
rtl/core/sequenced_event_ring.sv
test/sequenced_event_ring_tb.sv
